// File: hw/rtl/muxed_counter_position_extender_defines.svh
// Assertion macros used by the checker file.
// Each macro takes a label, a clock, a reset (active low), a condition and a result.
`ifndef MUXED_COUNTER_POSITION_EXTENDER_DEFINES_SVH
`define MUXED_COUNTER_POSITION_EXTENDER_DEFINES_SVH

// Same-cycle implication
`define MCPE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication
`define MCPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// File: hw/rtl/mcpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpe_pkg
// Shared types and fixed widths of the muxed counter position extender.
// ----------------------------------------------------------------------------
package mcpe_pkg;

    // byte lanes read through the two-way multiplexer
    localparam int LANES    = 4;
    localparam int COUNT_W  = 8;
    localparam int PINS_W   = LANES * COUNT_W;
    localparam int MASK_W   = 8;
    localparam int MODE_W   = 2;
    localparam int CH_W     = 3;
    localparam int FIELD_W  = 32;
    localparam int EXT_W    = 64;

    // operation carried by one input beat
    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2
    } t_mode;

endpackage

// File: hw/rtl/mcpe_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpe_lane
// One byte lane: glitch-checked count pick, wrapped delta, position add.
// ----------------------------------------------------------------------------
module mcpe_lane
    import mcpe_pkg::*;
#(
    parameter int POSITION_WIDTH = 32
) (
    input  logic [COUNT_W-1:0]        i_first,
    input  logic [COUNT_W-1:0]        i_second,
    input  logic [COUNT_W-1:0]        i_third,
    input  logic [COUNT_W-1:0]        i_prev,
    input  logic [POSITION_WIDTH-1:0] i_pos,
    output logic [COUNT_W-1:0]        o_count,
    output logic [POSITION_WIDTH-1:0] o_pos
);

    logic [COUNT_W-1:0]        diff;
    logic [POSITION_WIDTH-1:0] delta;

    // trust the first read only if the re-read agrees
    assign o_count = (i_first == i_second) ? i_first : i_third;

    // wrapped difference, sign-extended to the position width
    assign diff  = o_count - i_prev;
    assign delta = POSITION_WIDTH'(signed'(diff));
    assign o_pos = i_pos + delta;

endmodule

// File: hw/rtl/muxed_counter_position_extender.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// muxed_counter_position_extender
// Extends muxed 8-bit encoder counters into wrapping signed positions.
// ----------------------------------------------------------------------------
// One beat is accepted every cycle while the output is not stalled. Each beat
// passes an input register, is worked combinationally against the position and
// count registers, and lands in a result register. The four lane adders work in
// parallel and the state registers load together with the result register, so
// the next beat sees the new state at once. A tick samples the bank named by
// the select level and then flips it; read returns one position, write
// replaces one. A stalled result holds the pipeline back by at most the one
// beat in the input register.
module muxed_counter_position_extender
    import mcpe_pkg::*;
#(
    parameter int NUM_ENCODERS   = 8,
    parameter int POSITION_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [MASK_W-1:0]         i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [MODE_W-1:0]         i_mode,
    input  logic [PINS_W-1:0]         i_pins_first,
    input  logic [PINS_W-1:0]         i_pins_second,
    input  logic [PINS_W-1:0]         i_pins_third,
    input  logic [CH_W-1:0]           i_channel,
    input  logic signed [FIELD_W-1:0] i_write_value,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [FIELD_W-1:0] o_position,
    output logic                      o_select_level
);

    // input register
    logic                      r_in_valid;
    logic [MODE_W-1:0]         r_mode;
    logic [PINS_W-1:0]         r_first;
    logic [PINS_W-1:0]         r_second;
    logic [PINS_W-1:0]         r_third;
    logic [CH_W-1:0]           r_channel;
    logic signed [FIELD_W-1:0] r_wval;

    // state
    logic [MASK_W-1:0]         r_mask;
    logic                      r_bank;
    logic [POSITION_WIDTH-1:0] r_pos   [NUM_ENCODERS];
    logic [COUNT_W-1:0]        r_prev  [NUM_ENCODERS];
    logic [POSITION_WIDTH-1:0] n_pos   [NUM_ENCODERS];
    logic [COUNT_W-1:0]        n_prev  [NUM_ENCODERS];
    logic                      n_bank;

    // result register
    logic                      r_out_valid;
    logic signed [FIELD_W-1:0] r_res_pos;
    logic                      r_res_sel;
    logic signed [FIELD_W-1:0] n_res_pos;

    logic                      go;
    logic                      is_tick;
    logic                      is_read;
    logic                      is_write;
    logic signed [EXT_W-1:0]   wr_ext;
    logic signed [EXT_W-1:0]   rd_ext;
    logic signed [POSITION_WIDTH-1:0] rd_pos;

    logic [COUNT_W-1:0]        lane_prev  [LANES];
    logic [POSITION_WIDTH-1:0] lane_pos   [LANES];
    logic [COUNT_W-1:0]        lane_count [LANES];
    logic [POSITION_WIDTH-1:0] lane_new   [LANES];

    // advance when the result register is free or being emptied
    assign go         = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || go;

    // capture the input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_mode    <= i_mode;
            r_first   <= i_pins_first;
            r_second  <= i_pins_second;
            r_third   <= i_pins_third;
            r_channel <= i_channel;
            r_wval    <= i_write_value;
        end
    end

    // decode the operation
    always_comb begin
        is_tick  = 1'b0;
        is_read  = 1'b0;
        is_write = 1'b0;
        case (r_mode)
            MODE_TICK:  is_tick  = 1'b1;
            MODE_READ:  is_read  = 1'b1;
            MODE_WRITE: is_write = 1'b1;
            default: begin
            end
        endcase
    end

    // route each lane to the encoder of the current bank
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        localparam int EV = 2 * l;
        localparam int OD = 2 * l + 1;

        if (OD < NUM_ENCODERS) begin : g_pair
            assign lane_prev[l] = r_bank ? r_prev[OD] : r_prev[EV];
            assign lane_pos[l]  = r_bank ? r_pos[OD]  : r_pos[EV];
        end else if (EV < NUM_ENCODERS) begin : g_even
            assign lane_prev[l] = r_prev[EV];
            assign lane_pos[l]  = r_pos[EV];
        end else begin : g_none
            assign lane_prev[l] = '0;
            assign lane_pos[l]  = '0;
        end

        mcpe_lane #(
            .POSITION_WIDTH (POSITION_WIDTH)
        ) u_lane (
            .i_first  (r_first[COUNT_W*l +: COUNT_W]),
            .i_second (r_second[COUNT_W*l +: COUNT_W]),
            .i_third  (r_third[COUNT_W*l +: COUNT_W]),
            .i_prev   (lane_prev[l]),
            .i_pos    (lane_pos[l]),
            .o_count  (lane_count[l]),
            .o_pos    (lane_new[l])
        );
    end

    // widen the write value and the read value to the extended width
    assign wr_ext = EXT_W'(r_wval);
    assign rd_ext = EXT_W'(rd_pos);

    // update positions and counts; pick the read position
    always_comb begin
        rd_pos = '0;
        for (int e = 0; e < NUM_ENCODERS; e++) begin
            n_pos[e]  = r_pos[e];
            n_prev[e] = r_prev[e];
            if (go && is_tick && (e < MASK_W) && r_mask[e % MASK_W]
                    && ((e % 2) == int'(r_bank))) begin
                n_pos[e]  = lane_new[(e / 2) % LANES];
                n_prev[e] = lane_count[(e / 2) % LANES];
            end
            if (go && is_write && (32'(r_channel) == e)) begin
                n_pos[e] = wr_ext[POSITION_WIDTH-1:0];
            end
            if (32'(r_channel) == e) begin
                rd_pos = r_pos[e];
            end
        end
        n_bank    = r_bank ^ (go && is_tick);
        n_res_pos = is_read ? rd_ext[FIELD_W-1:0] : '0;
    end

    // hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= 1'b0;
            for (int e = 0; e < NUM_ENCODERS; e++) begin
                r_pos[e]  <= '0;
                r_prev[e] <= '0;
            end
        end else begin
            r_bank <= n_bank;
            for (int e = 0; e < NUM_ENCODERS; e++) begin
                r_pos[e]  <= n_pos[e];
                r_prev[e] <= n_prev[e];
            end
        end
    end

    // enable mask register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '1;
        end else if (i_cfg_we) begin
            r_mask <= i_cfg_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_res_pos <= n_res_pos;
            r_res_sel <= n_bank;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_position     = r_res_pos;
    assign o_select_level = r_res_sel;

endmodule

// File: hw/rtl/mcpe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpe_checker
// Port-level checks of the position extender, bound to the top level.
// ----------------------------------------------------------------------------
`include "muxed_counter_position_extender_defines.svh"

module mcpe_checker
    import mcpe_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_ready,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic signed [FIELD_W-1:0] o_position,
    input logic                      o_select_level
);

    // hold a stalled result beat
    `MCPE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_position) && $stable(o_select_level))

    // take input whenever no result is pending
    `MCPE_ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready)

    // a fresh result follows a beat accepted into the input register and then moved to the result register
    `MCPE_ASSERT_IMPL(a_no_invented, i_clk, i_rst_n, o_out_valid && !$past(o_out_valid), $past(i_in_valid && o_in_ready, 2))

endmodule

bind muxed_counter_position_extender mcpe_checker u_mcpe_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_position     (o_position),
    .o_select_level (o_select_level)
);
